// ===== rtl/cxfc_pkg.sv =====
// Shared types, constants and CRC/keystream functions of the frame checker.
package cxfc_pkg;

    localparam int POS_W = 17;

    localparam logic [POS_W-1:0] HDR_BYTES = 17'd12;
    localparam logic [POS_W-1:0] POS_MAX   = 17'h1FFFF;

    // Header byte positions
    localparam logic [POS_W-1:0] POS_MAGIC_LO = 17'd0;
    localparam logic [POS_W-1:0] POS_MAGIC_HI = 17'd1;
    localparam logic [POS_W-1:0] POS_VERSION  = 17'd2;
    localparam logic [POS_W-1:0] POS_TYPE     = 17'd3;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd5;
    localparam logic [POS_W-1:0] POS_SUM_B0   = 17'd6;
    localparam logic [POS_W-1:0] POS_SUM_B1   = 17'd7;
    localparam logic [POS_W-1:0] POS_SUM_B2   = 17'd8;
    localparam logic [POS_W-1:0] POS_SUM_B3   = 17'd9;

    localparam logic [15:0] FRAME_MAGIC   = 16'hAF41;
    localparam logic [7:0]  FRAME_VERSION = 8'd1;
    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
    localparam logic [31:0] SEED_MIX      = 32'h9E3779B9;

    // APB register map
    localparam int          APB_AW               = 3;
    localparam logic [APB_AW-1:0] REG_SESSION_KEY = 3'd0;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cxfc_item_t;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  frame_type;
        logic        frame_ok;
        logic        frame_done;
        logic        byte_is_payload;
        logic [7:0]  byte_out;
    } cxfc_result_t;

    // One byte of reflected CRC-32, bit at a time (eight XOR/shift layers)
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // xorshift32 step, shifts 13/17/5
    function automatic logic [31:0] xs_next(input logic [31:0] s_in);
        logic [31:0] s;
        s = s_in;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        return s;
    endfunction

endpackage

// ===== rtl/crc_xorshift_frame_checker_top.sv =====
// Top level of the CRC-32 / xorshift32 frame checker.
// An accepted item waits in the input register until the core takes it, then moves to the result register.
// Throughput: one item per cycle while m_tready stays high; CRC and keystream step are one combinational pass.
// A stalled result register holds its item while the input register still takes one more.
// Reset (aresetn low, synchronous): channels empty, frame state cleared, CRC all ones,
//   session_key zero.
module crc_xorshift_frame_checker_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB config
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cxfc_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // received byte stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] byte_in
    input  logic                        s_tlast,   // end_of_frame
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] byte_out, [8] frame_ok, [16:9] frame_type, [32:17] payload_length, rest zero
    output logic [39:0]                 m_tdata,
    output logic                        m_tuser,   // byte_is_payload
    output logic                        m_tlast    // frame_done
);
    import cxfc_pkg::*;

    logic [31:0]  key;
    logic         item_valid;
    cxfc_item_t   item;
    logic         take;
    cxfc_result_t result;

    // Key register; the user must write it only while the stream is idle (the block does not enforce this).
    cxfc_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .session_key (key)
    );

    // Input register: frees s_tready whenever the core takes the held item.
    cxfc_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Header capture, descramble, CRC, verdict and result register.
    cxfc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .item        (item),
        .session_key (key),
        .take        (take),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .result      (result)
    );

    // Result packing
    assign m_tdata = {7'd0, result.payload_length, result.frame_type, result.frame_ok,
                      result.byte_out};
    assign m_tuser = result.byte_is_payload;
    assign m_tlast = result.frame_done;

endmodule

// ===== rtl/cxfc_apb_regs.sv =====
// APB register block holding the session key.
module cxfc_apb_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cxfc_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [31:0]                  session_key
);
    import cxfc_pkg::*;

    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_SESSION_KEY);

    always_comb begin
        key_next = key_reg;
        if (wr_en) begin
            key_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    assign prdata      = (paddr == REG_SESSION_KEY) ? key_reg : 32'd0;
    assign session_key = key_reg;

endmodule

// ===== rtl/cxfc_in_reg.sv =====
// Input register stage of the byte stream.
module cxfc_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 take,
    output logic                 item_valid,
    output cxfc_pkg::cxfc_item_t item
);
    import cxfc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    cxfc_item_t item_reg;
    logic       load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.data <= s_tdata;
            item_reg.last <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/cxfc_core.sv =====
// Frame state, descramble/CRC update and result register.
module cxfc_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    input  cxfc_pkg::cxfc_item_t   item,
    input  logic [31:0]            session_key,
    output logic                   take,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output cxfc_pkg::cxfc_result_t result
);
    import cxfc_pkg::*;

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [15:0]      magic_reg, magic_next;
    logic [7:0]       ver_reg,   ver_next;
    logic [7:0]       type_reg,  type_next;
    logic [15:0]      len_reg,   len_next;
    logic [31:0]      sum_reg,   sum_next;
    logic [31:0]      crc_reg,   crc_next;
    logic [31:0]      ks_reg,    ks_next;
    logic             out_valid_reg, out_valid_next;
    cxfc_result_t     res_reg,   res_next;

    logic [31:0]      ks_cur;
    logic [31:0]      ks_adv;
    logic [7:0]       plain;
    logic             is_hdr;
    logic             is_pay;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] pay_end;
    logic [POS_W-1:0] need_len;
    logic [15:0]      magic_u;
    logic [7:0]       ver_u;
    logic [7:0]       type_u;
    logic [15:0]      len_u;
    logic [31:0]      sum_u;
    logic [31:0]      crc_u;
    logic             ok;

    assign take = item_valid && (!out_valid_reg || m_tready);

    // Keystream reseeds on the first byte of a frame
    assign ks_cur   = (pos_reg == '0) ? (session_key ^ SEED_MIX) : ks_reg;
    assign ks_adv   = xs_next(ks_cur);
    assign plain    = item.data ^ ks_adv[31:24];
    assign is_hdr   = pos_reg < HDR_BYTES;
    assign pay_end  = HDR_BYTES + {1'b0, len_reg};
    assign is_pay   = !is_hdr && (pos_reg < pay_end);
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    always_comb begin
        magic_u = magic_reg;
        ver_u   = ver_reg;
        type_u  = type_reg;
        len_u   = len_reg;
        sum_u   = sum_reg;
        case (pos_reg)
            POS_MAGIC_LO: magic_u[7:0]  = item.data;
            POS_MAGIC_HI: magic_u[15:8] = item.data;
            POS_VERSION:  ver_u         = item.data;
            POS_TYPE:     type_u        = item.data;
            POS_LEN_LO:   len_u[7:0]    = item.data;
            POS_LEN_HI:   len_u[15:8]   = item.data;
            POS_SUM_B0:   sum_u[7:0]    = item.data;
            POS_SUM_B1:   sum_u[15:8]   = item.data;
            POS_SUM_B2:   sum_u[23:16]  = item.data;
            POS_SUM_B3:   sum_u[31:24]  = item.data;
            default: ;
        endcase
    end

    assign crc_u    = is_pay ? crc_byte(crc_reg, plain) : crc_reg;
    assign need_len = HDR_BYTES + {1'b0, len_u};
    assign ok       = (magic_u == FRAME_MAGIC) && (ver_u == FRAME_VERSION) &&
                      (pos_inc >= need_len) && ((~crc_u ^ session_key) == sum_u);

    always_comb begin
        pos_next   = pos_reg;
        magic_next = magic_reg;
        ver_next   = ver_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        crc_next   = crc_reg;
        ks_next    = ks_reg;
        res_next   = res_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (take) begin
            out_valid_next           = 1'b1;
            res_next.byte_out        = is_pay ? plain : 8'd0;
            res_next.byte_is_payload = is_pay;
            res_next.frame_done      = item.last;
            res_next.frame_ok        = item.last && ok;
            res_next.frame_type      = item.last ? type_u : 8'd0;
            res_next.payload_length  = item.last ? len_u : 16'd0;
            ks_next                  = is_pay ? ks_adv : ks_cur;
            if (item.last) begin
                pos_next   = '0;
                magic_next = '0;
                ver_next   = '0;
                type_next  = '0;
                len_next   = '0;
                sum_next   = '0;
                crc_next   = CRC_INIT;
            end else begin
                pos_next   = pos_inc;
                magic_next = magic_u;
                ver_next   = ver_u;
                type_next  = type_u;
                len_next   = len_u;
                sum_next   = sum_u;
                crc_next   = crc_u;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            magic_reg     <= '0;
            ver_reg       <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            magic_reg     <= magic_next;
            ver_reg       <= ver_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ks_reg  <= ks_next;
        res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign result   = res_reg;

    // frame end clears frame state
    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && item.last) |=> (pos_reg == '0 && crc_reg == CRC_INIT && len_reg == '0))
        else $error("frame state not cleared after end of frame");

    // only header-free positions carry payload
    a_pay_after_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && is_pay) |-> (pos_reg >= HDR_BYTES))
        else $error("payload flagged inside header");

    // verdict fields only on frame_done results
    a_verdict_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !res_reg.frame_done) |->
        (!res_reg.frame_ok && res_reg.frame_type == '0 && res_reg.payload_length == '0))
        else $error("verdict fields set on non-final result");

    // byte_out is zero unless it is a payload byte
    a_byte_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !res_reg.byte_is_payload) |-> (res_reg.byte_out == '0))
        else $error("byte_out nonzero outside payload");

endmodule

// ===== dv/tb_crc_xorshift_frame_checker_top.sv =====
// Self-checking testbench for the CRC-32 / xorshift32 frame checker top level.
module tb_crc_xorshift_frame_checker_top;
    import cxfc_pkg::*;

    // Generous bound for about 800 items behind a stalling receiver.
    localparam int CYCLE_LIMIT = 100_000;
    localparam int PRINT_LIMIT = 40;

    // Ways a generated frame can be spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_SUM,
        FLAW_DATA,
        FLAW_SHORT,
        FLAW_NOISE
    } flaw_t;

    // Receiver back-pressure styles
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_THREE_OF_FOUR,
        RX_TRICKLE
    } rx_mode_t;

    // Per-byte frame checker model plus the queue of results still owed by the block.
    class frame_verdict_model;
        logic [31:0]      session_key;
        logic [POS_W-1:0] pos;
        logic [15:0]      magic;
        logic [7:0]       version;
        logic [7:0]       ftype;
        logic [15:0]      length;
        logic [31:0]      stored_sum;
        logic [31:0]      crc;
        logic [31:0]      keystream;
        cxfc_result_t     pending_byte_results[$];
        int               mismatch_count;
        int               result_index;

        function new();
            session_key    = '0;
            mismatch_count = 0;
            result_index   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos        = '0;
            magic      = '0;
            version    = '0;
            ftype      = '0;
            length     = '0;
            stored_sum = '0;
            crc        = CRC_INIT;
            keystream  = session_key ^ SEED_MIX;
        endfunction

        // reflected CRC-32, one bit per pass
        static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++) begin
                if (r[0]) begin
                    r = (r >> 1) ^ CRC_POLY;
                end else begin
                    r = r >> 1;
                end
            end
            return r;
        endfunction

        static function logic [31:0] ks_advance(logic [31:0] s);
            logic [31:0] t;
            t = s ^ (s << 13);
            t = t ^ (t >> 17);
            t = t ^ (t << 5);
            return t;
        endfunction

        function int pending();
            return pending_byte_results.size();
        endfunction

        // One accepted input byte -> exactly one expected result
        function void take_byte(logic [7:0] b, logic last);
            cxfc_result_t want;
            logic [7:0]   plain;
            want = '0;
            if (pos == '0) begin
                keystream = session_key ^ SEED_MIX;
            end
            if (pos < HDR_BYTES) begin
                case (pos)
                    POS_MAGIC_LO: magic[7:0]        = b;
                    POS_MAGIC_HI: magic[15:8]       = b;
                    POS_VERSION:  version           = b;
                    POS_TYPE:     ftype             = b;
                    POS_LEN_LO:   length[7:0]       = b;
                    POS_LEN_HI:   length[15:8]      = b;
                    POS_SUM_B0:   stored_sum[7:0]   = b;
                    POS_SUM_B1:   stored_sum[15:8]  = b;
                    POS_SUM_B2:   stored_sum[23:16] = b;
                    POS_SUM_B3:   stored_sum[31:24] = b;
                    default: ;
                endcase
            end else if (int'(pos) < int'(HDR_BYTES) + int'(length)) begin
                keystream            = ks_advance(keystream);
                plain                = b ^ keystream[31:24];
                crc                  = crc_step(crc, plain);
                want.byte_out        = plain;
                want.byte_is_payload = 1'b1;
            end
            if (pos != POS_MAX) begin
                pos = pos + 1'b1;
            end
            if (last) begin
                want.frame_done     = 1'b1;
                want.frame_ok       = (magic == FRAME_MAGIC) && (version == FRAME_VERSION) &&
                                      (int'(pos) >= int'(HDR_BYTES) + int'(length)) &&
                                      (((~crc) ^ session_key) == stored_sum);
                want.frame_type     = ftype;
                want.payload_length = length;
                clear_frame();
            end
            pending_byte_results.insert(pending_byte_results.size(), want);
        endfunction

        task report(string what);
            mismatch_count++;
            if (mismatch_count <= PRINT_LIMIT) begin
                $display("ERROR @%0t result %0d: %s", $time, result_index, what);
            end
        endtask

        task check_result(cxfc_result_t got);
            cxfc_result_t want;
            if (pending_byte_results.size() == 0) begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = pending_byte_results.pop_front();
            if (got.byte_out !== want.byte_out)
                report($sformatf("byte_out %h, want %h", got.byte_out, want.byte_out));
            if (got.byte_is_payload !== want.byte_is_payload)
                report($sformatf("byte_is_payload %b, want %b",
                                 got.byte_is_payload, want.byte_is_payload));
            if (got.frame_done !== want.frame_done)
                report($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
            if (got.frame_ok !== want.frame_ok)
                report($sformatf("frame_ok %b, want %b", got.frame_ok, want.frame_ok));
            if (got.frame_type !== want.frame_type)
                report($sformatf("frame_type %h, want %h", got.frame_type, want.frame_type));
            if (got.payload_length !== want.payload_length)
                report($sformatf("payload_length %h, want %h",
                                 got.payload_length, want.payload_length));
            result_index++;
        endtask
    endclass

    // ---------------------------------------------------------------- signals
    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;   // [7:0] byte_in
    logic              s_tlast  = 1'b0; // end_of_frame
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // [7:0] byte_out, [8] frame_ok, [16:9] frame_type, [32:17] payload_length
    logic [39:0]       m_tdata;
    logic              m_tuser;         // byte_is_payload
    logic              m_tlast;         // frame_done

    frame_verdict_model byte_model;
    cxfc_item_t         frame_bytes[$];   // frame under construction, one entry per item
    cxfc_result_t       seen;
    logic [31:0]        cur_key    = '0;
    int                 burst_left = 0;
    int                 gap_max    = 6;
    int                 bytes_sent = 0;
    int                 cycle_count = 0;
    logic [7:0]         rx_phase   = '0;
    rx_mode_t           rx_mode    = RX_OPEN;

    crc_xorshift_frame_checker_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("crc_xorshift_frame_checker_top: mismatch");
            $finish;
        end
    end

    // Receiver stall pattern: a new style each time rx_phase[5:0] wraps to zero, from always-ready to a trickle.
    always @(negedge aclk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_phase[5:0] == '0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:          m_tready <= 1'b1;
            RX_COIN:          m_tready <= 1'($urandom_range(0, 1));
            RX_THREE_OF_FOUR: m_tready <= (rx_phase[1:0] != 2'd0);
            default:          m_tready <= (rx_phase[1:0] == 2'd0);
        endcase
    end

    // Both handshakes are sampled at the rising edge; inputs are noted before results are checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                byte_model.take_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                seen.byte_out        = m_tdata[7:0];
                seen.frame_ok        = m_tdata[8];
                seen.frame_type      = m_tdata[16:9];
                seen.payload_length  = m_tdata[32:17];
                seen.byte_is_payload = m_tuser;
                seen.frame_done      = m_tlast;
                byte_model.check_result(seen);
            end
        end
    end

    // ---------------------------------------------------------------- sender side
    // Drop valid when n is nonzero; data lines carry junk meanwhile.
    task automatic hold_off(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // One item; valid stays high afterwards so back-to-back items have no bubble.
    task automatic send_byte(input cxfc_item_t it);
        if (burst_left == 0) begin
            hold_off($urandom_range(0, gap_max));
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= it.data;
        s_tlast  <= it.last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_span(input int first, input int stop);
        for (int i = first; i < stop; i++) begin
            send_byte(frame_bytes[i]);
        end
    endtask

    // Lower valid, then wait out every outstanding result plus the pipeline depth.
    task automatic wait_all_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (byte_model.pending() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // Setup then access phase; the register takes pwdata at the edge inside the access phase.
    task automatic write_session_key(input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SESSION_KEY;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        byte_model.session_key = value;
        cur_key = value;
    endtask

    task automatic push_byte(input logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), '{data: b, last: 1'b0});
    endtask

    // Builds a scrambled frame in frame_bytes. The keystream is seeded from seed_key,
    // the checksum is made for sum_key (they differ only when the key changes mid-frame).
    task automatic build_frame(input logic [31:0] seed_key, input logic [31:0] sum_key,
                               input logic [7:0] ftype, input int len, input int trailer,
                               input flaw_t flaw);
        logic [7:0]  plain[$];
        logic [31:0] crc;
        logic [31:0] ks;
        logic [31:0] sum;
        int          at;
        int          cut;
        int          n;
        frame_bytes.delete();
        crc = CRC_INIT;
        for (int i = 0; i < len; i++) begin
            plain.insert(i, 8'($urandom));
            crc = frame_verdict_model::crc_step(crc, plain[i]);
        end
        sum = (~crc) ^ sum_key;
        push_byte(FRAME_MAGIC[7:0]);
        push_byte(FRAME_MAGIC[15:8]);
        push_byte(FRAME_VERSION);
        push_byte(ftype);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        push_byte(sum[7:0]);
        push_byte(sum[15:8]);
        push_byte(sum[23:16]);
        push_byte(sum[31:24]);
        push_byte(8'($urandom));   // reserved
        push_byte(8'($urandom));
        ks = seed_key ^ SEED_MIX;
        foreach (plain[i]) begin
            ks = frame_verdict_model::ks_advance(ks);
            push_byte(plain[i] ^ ks[31:24]);
        end
        repeat (trailer) push_byte(8'($urandom));
        case (flaw)
            FLAW_MAGIC: begin
                at = $urandom_range(0, 1);
                frame_bytes[at].data ^= 8'($urandom_range(1, 255));
            end
            FLAW_VERSION: frame_bytes[2].data ^= 8'($urandom_range(1, 255));
            FLAW_SUM: begin
                at = $urandom_range(6, 9);
                frame_bytes[at].data ^= 8'($urandom_range(1, 255));
            end
            FLAW_DATA: begin
                at = (len > 0) ? 12 + $urandom_range(0, len - 1) : 6;
                frame_bytes[at].data ^= 8'($urandom_range(1, 255));
            end
            FLAW_SHORT: begin
                // end of frame lands inside the header or the payload
                cut = $urandom_range(1, 12 + len - 1);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
            FLAW_NOISE: begin
                frame_bytes.delete();
                n = $urandom_range(1, 20);
                repeat (n) push_byte(8'($urandom));
            end
            default: ;
        endcase
        frame_bytes[frame_bytes.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------- stimulus
    initial begin
        flaw_t       flaw;
        int          pick;
        int          len;
        int          trailer;
        logic [31:0] key;

        byte_model = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // Single-byte frame: ends at position 0, type and length report zero, verdict false.
        frame_bytes.delete();
        frame_bytes.insert(0, '{data: 8'hFF, last: 1'b1});
        send_span(0, 1);

        // Empty payload, type all ones: CRC of nothing still checks out.
        build_frame(cur_key, cur_key, 8'hFF, 0, 0, FLAW_NONE);
        send_span(0, frame_bytes.size());

        // Key changed mid-frame: keystream keeps the old seed, the checksum uses the new key.
        // Trailing bytes past the payload, end of frame on the last of them.
        build_frame(cur_key, 32'hFFFF_FFFF, 8'h00, 1, 2, FLAW_NONE);
        send_span(0, 7);
        wait_all_results();
        write_session_key(32'hFFFF_FFFF);
        send_span(7, frame_bytes.size());
        wait_all_results();

        // --- random frames, mostly well formed ---
        while (bytes_sent < 780) begin
            if ($urandom_range(0, 7) == 0) begin
                wait_all_results();
                case ($urandom_range(0, 3))
                    0:       key = 32'h0;
                    1:       key = 32'hFFFF_FFFF;
                    default: key = $urandom;
                endcase
                write_session_key(key);
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)      flaw = FLAW_NONE;
            else if (pick < 66) flaw = FLAW_MAGIC;
            else if (pick < 72) flaw = FLAW_VERSION;
            else if (pick < 78) flaw = FLAW_SUM;
            else if (pick < 84) flaw = FLAW_DATA;
            else if (pick < 92) flaw = FLAW_SHORT;
            else                flaw = FLAW_NOISE;
            len     = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 200)
                                                   : $urandom_range(0, 24);
            trailer = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            build_frame(cur_key, cur_key, 8'($urandom), len, trailer, flaw);
            send_span(0, frame_bytes.size());
        end

        wait_all_results();
        repeat (8) @(posedge aclk);
        if (byte_model.mismatch_count == 0 && byte_model.pending() == 0) begin
            $display("crc_xorshift_frame_checker_top: match");
        end else begin
            $display("crc_xorshift_frame_checker_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cxfc_pkg.sv
rtl/cxfc_apb_regs.sv
rtl/cxfc_in_reg.sv
rtl/cxfc_core.sv
rtl/crc_xorshift_frame_checker_top.sv
dv/tb_crc_xorshift_frame_checker_top.sv
